/* design/qtm_pkg.sv */
// ---------------------------------------------------------------------------
// qtm_pkg
// Shared types and defaults for the quantile tie mean substitution block.
// ---------------------------------------------------------------------------
package qtm_pkg;

  localparam int TIE_DEPTH_DEF  = 32;
  localparam int VALUE_BITS_DEF = 16;

  localparam int SORT_W = 16;
  localparam int POS_W  = 32;
  localparam int MEAN_W = 32;

  typedef struct packed {
    logic [SORT_W-1:0] sort_value;
    logic [POS_W-1:0]  position;
    logic [MEAN_W-1:0] rank_mean;
    logic              is_last;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0]  out_position;
    logic [MEAN_W-1:0] norm_value;
    logic              run_end;
    logic              split_flag;
  } out_item_t;

endpackage

/* design/quantile_tie_mean_substitute.sv */
// ---------------------------------------------------------------------------
// quantile_tie_mean_substitute
// Tie-averaging substitution of quantile means over a sorted stream.
// ---------------------------------------------------------------------------
// The block holds one item back and compares it with the next. An isolated
// item passes through the held and new states (and the last state when it
// carries is_last) before the block is ready again, and gives its own mean.
// A run of equal sort values is gathered in a position buffer; when it
// closes, the sum of its means is divided by its length in a bit-serial
// divider (NUM_W = 32 + count width steps), then every buffered position is
// read back and emitted, each result passing a read state and then an emit
// state, since the buffer's read port is registered. A run that fills the
// buffer is flushed with split_flag set. The block takes a new transaction
// only once all results of the previous one are issued.
module quantile_tie_mean_substitute #(
  parameter int TIE_DEPTH  = qtm_pkg::TIE_DEPTH_DEF,
  parameter int VALUE_BITS = qtm_pkg::VALUE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  qtm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output qtm_pkg::out_item_t out_data
);
  import qtm_pkg::*;

  localparam int CNT_W = $clog2(TIE_DEPTH + 1);
  localparam int AW    = $clog2(TIE_DEPTH);
  localparam int SUM_W = MEAN_W + CNT_W;
  localparam int CMP_W = (VALUE_BITS < SORT_W) ? VALUE_BITS : SORT_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_HELD  = 3'd1;
  localparam logic [2:0] ST_NEW   = 3'd2;
  localparam logic [2:0] ST_LAST  = 3'd3;
  localparam logic [2:0] ST_DIVGO = 3'd4;
  localparam logic [2:0] ST_DIVWT = 3'd5;
  localparam logic [2:0] ST_RD    = 3'd6;
  localparam logic [2:0] ST_EMIT  = 3'd7;

  logic [2:0]        state_r, state_nxt;
  in_item_t          item_r;
  logic              held_valid_r, held_valid_nxt;
  logic [SORT_W-1:0] held_value_r, held_value_nxt;
  logic [POS_W-1:0]  held_pos_r, held_pos_nxt;
  logic [MEAN_W-1:0] held_mean_r, held_mean_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [MEAN_W-1:0] avg_r, avg_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic              split_r, split_nxt;
  logic              ret_idle_r, ret_idle_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic              out_free;
  logic              in_take;
  logic              same_value;
  logic              last_entry;
  logic              ram_we;
  logic              ram_re;
  logic [POS_W-1:0]  ram_rdata;
  logic              div_start;
  logic              div_done;
  logic [SUM_W-1:0]  div_quot;
  logic [SUM_W-1:0]  div_num;

  assign out_free   = !out_valid_r || !out_stall;
  assign in_take    = in_valid && (state_r == ST_IDLE);
  assign same_value = held_value_r[CMP_W-1:0] == item_r.sort_value[CMP_W-1:0];
  assign last_entry = (idx_r + CNT_W'(1)) == cnt_r;
  assign div_num    = sum_r + SUM_W'(cnt_r >> 1);

  qtm_tie_ram #(
    .DEPTH (TIE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (held_pos_r),
    .re    (ram_re),
    .raddr (idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  qtm_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (cnt_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    state_nxt      = state_r;
    held_valid_nxt = held_valid_r;
    held_value_nxt = held_value_r;
    held_pos_nxt   = held_pos_r;
    held_mean_nxt  = held_mean_r;
    cnt_nxt        = cnt_r;
    sum_nxt        = sum_r;
    avg_nxt        = avg_r;
    idx_nxt        = idx_r;
    split_nxt      = split_r;
    ret_idle_nxt   = ret_idle_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    div_start      = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          state_nxt = ST_HELD;
        end
      end
      ST_HELD: begin
        if (!held_valid_r) begin
          state_nxt = ST_NEW;
        end else if (same_value) begin
          ram_we    = 1'b1;
          cnt_nxt   = cnt_r + CNT_W'(1);
          sum_nxt   = sum_r + SUM_W'(held_mean_r);
          split_nxt = 1'b1;
          ret_idle_nxt = 1'b0;
          // A run that fills the buffer while still going on is split here.
          state_nxt = (cnt_r + CNT_W'(1) == CNT_W'(TIE_DEPTH)) ? ST_DIVGO : ST_NEW;
        end else if (cnt_r == '0) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{held_pos_r, held_mean_r, !item_r.is_last, 1'b0};
            state_nxt     = ST_NEW;
          end
        end else begin
          ram_we       = 1'b1;
          cnt_nxt      = cnt_r + CNT_W'(1);
          sum_nxt      = sum_r + SUM_W'(held_mean_r);
          split_nxt    = 1'b0;
          ret_idle_nxt = 1'b0;
          state_nxt    = ST_DIVGO;
        end
      end
      ST_NEW: begin
        held_valid_nxt = 1'b1;
        held_value_nxt = item_r.sort_value;
        held_pos_nxt   = item_r.position;
        held_mean_nxt  = item_r.rank_mean;
        state_nxt      = item_r.is_last ? ST_LAST : ST_IDLE;
      end
      ST_LAST: begin
        if (cnt_r == '0) begin
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_data_nxt   = '{held_pos_r, held_mean_r, 1'b1, 1'b0};
            held_valid_nxt = 1'b0;
            state_nxt      = ST_IDLE;
          end
        end else begin
          ram_we       = 1'b1;
          cnt_nxt      = cnt_r + CNT_W'(1);
          sum_nxt      = sum_r + SUM_W'(held_mean_r);
          split_nxt    = 1'b0;
          ret_idle_nxt = 1'b1;
          state_nxt    = ST_DIVGO;
        end
      end
      ST_DIVGO: begin
        div_start = 1'b1;
        idx_nxt   = '0;
        state_nxt = ST_DIVWT;
      end
      ST_DIVWT: begin
        if (div_done) begin
          avg_nxt   = div_quot[MEAN_W-1:0];
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        ram_re    = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{ram_rdata, avg_r,
                            last_entry && (ret_idle_r || !item_r.is_last), split_r};
          if (last_entry) begin
            cnt_nxt = '0;
            sum_nxt = '0;
            if (ret_idle_r) begin
              held_valid_nxt = 1'b0;
              state_nxt      = ST_IDLE;
            end else begin
              state_nxt = ST_NEW;
            end
          end else begin
            idx_nxt   = idx_r + CNT_W'(1);
            state_nxt = ST_RD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      held_valid_r <= 1'b0;
      cnt_r        <= '0;
      sum_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      held_valid_r <= held_valid_nxt;
      cnt_r        <= cnt_nxt;
      sum_r        <= sum_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    if (in_take) begin
      item_r <= in_data;
    end
    held_value_r <= held_value_nxt;
    held_pos_r   <= held_pos_nxt;
    held_mean_r  <= held_mean_nxt;
    avg_r        <= avg_nxt;
    idx_r        <= idx_nxt;
    split_r      <= split_nxt;
    ret_idle_r   <= ret_idle_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign in_stall  = state_r != ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* design/qtm_div.sv */
// ---------------------------------------------------------------------------
// qtm_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module qtm_div #(
  parameter int NUM_W = 38,
  parameter int DEN_W = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);
  localparam int STEP_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  q_r, q_nxt;
  logic [DEN_W:0]    rem_r, rem_nxt;
  logic [DEN_W-1:0]  den_r;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DEN_W:0]    rem_sh;
  logic [DEN_W:0]    rem_sub;

  always_comb begin
    rem_sh   = {rem_r[DEN_W-1:0], q_r[NUM_W-1]};
    rem_sub  = rem_sh - {1'b0, den_r};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = num;
      rem_nxt  = '0;
      step_nxt = STEP_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // Shift one dividend bit into the remainder and try the subtraction.
      if (rem_sh >= {1'b0, den_r}) begin
        rem_nxt = rem_sub;
        q_nxt   = {q_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        q_nxt   = {q_r[NUM_W-2:0], 1'b0};
      end
      step_nxt = step_r - STEP_W'(1);
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

/* design/qtm_tie_ram.sv */
// ---------------------------------------------------------------------------
// qtm_tie_ram
// Position buffer for a tie run: one write port, one registered read port.
// ---------------------------------------------------------------------------
module qtm_tie_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic [qtm_pkg::POS_W-1:0] wdata,
  input  logic                     re,
  input  logic [AW-1:0]            raddr,
  output logic [qtm_pkg::POS_W-1:0] rdata
);
  import qtm_pkg::*;

  logic [POS_W-1:0] mem [DEPTH];
  logic [POS_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/qtm_checker.sv */
// ---------------------------------------------------------------------------
// qtm_checker
// Port-level checks for the quantile tie mean substitution block.
// ---------------------------------------------------------------------------
module qtm_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input qtm_pkg::out_item_t out_data
);
  import qtm_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result changed");

  // Each transaction is worked on before the next one is taken.
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction taken without a busy cycle");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

endmodule

bind quantile_tie_mean_substitute qtm_checker u_qtm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

/* sim/tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for quantile_tie_mean_substitute: a tie-averaging
// predictor runs alongside the block, and a scoreboard compares every result
// transaction field by field against the oldest predicted one.
// ---------------------------------------------------------------------------
module tb;
  import qtm_pkg::*;

  localparam int DEPTH    = TIE_DEPTH_DEF;
  localparam int WD_LIMIT = 20000;

  class tie_scoreboard;
    bit              have_held;
    logic [15:0]     held_val;
    logic [31:0]     held_pos;
    logic [31:0]     held_mean;
    logic [31:0]     run_pos[DEPTH];
    int              run_len;
    logic [36:0]     run_sum;
    out_item_t       pending[$];
    int              errors;

    function void clear();
      have_held = 0;
      run_len = 0;
      run_sum = '0;
      pending.delete();
      errors = 0;
    endfunction

    function void push(logic [31:0] p, logic [31:0] v, bit split);
      out_item_t r;
      r.out_position = p;
      r.norm_value = v;
      r.run_end = 1'b0;
      r.split_flag = split;
      pending.insert(pending.size(), r);
    endfunction

    function bit add_to_run(logic [31:0] p, logic [31:0] m);
      if (run_len < DEPTH) begin
        run_pos[run_len] = p;
        run_len++;
        run_sum += m;
      end
      return run_len >= DEPTH;
    endfunction

    function void drain_run(bit split);
      logic [36:0] avg;
      avg = '0;
      if (run_len != 0) avg = (run_sum + run_len / 2) / run_len;
      for (int i = 0; i < run_len; i++) push(run_pos[i], avg[31:0], split);
      run_len = 0;
      run_sum = '0;
    endfunction

    function void close_held();
      if (run_len == 0) push(held_pos, held_mean, 0);
      else begin
        void'(add_to_run(held_pos, held_mean));
        drain_run(0);
      end
    endfunction

    // Notes an accepted input transaction and predicts its results.
    function void note_input(in_item_t it);
      int start;
      start = pending.size();
      if (have_held) begin
        if (held_val == it.sort_value) begin
          if (add_to_run(held_pos, held_mean)) drain_run(1);
        end else begin
          close_held();
        end
      end
      have_held = 1;
      held_val = it.sort_value;
      held_pos = it.position;
      held_mean = it.rank_mean;
      if (it.is_last) begin
        close_held();
        have_held = 0;
      end
      if (pending.size() > start) pending[pending.size()-1].run_end = 1'b1;
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.out_position !== exp.out_position) begin
        $display("%0t: out_position exp %h got %h", $time, exp.out_position,
                 got.out_position);
        errors++;
      end
      if (got.norm_value !== exp.norm_value) begin
        $display("%0t: norm_value exp %h got %h", $time, exp.norm_value,
                 got.norm_value);
        errors++;
      end
      if (got.run_end !== exp.run_end) begin
        $display("%0t: run_end exp %b got %b", $time, exp.run_end, got.run_end);
        errors++;
      end
      if (got.split_flag !== exp.split_flag) begin
        $display("%0t: split_flag exp %b got %b", $time, exp.split_flag,
                 got.split_flag);
        errors++;
      end
    endfunction
  endclass

  logic      clk = 0;
  logic      rst_n = 0;
  logic      in_valid = 0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 0;
  out_item_t out_data;

  tie_scoreboard sb;
  bit  calm = 0;
  bit  hold_off = 0;
  int  idle_cycles = 0;
  logic [15:0] cur_val = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  quantile_tie_mean_substitute i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Input and output acceptance, plus the watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_input(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  // Receiver stall: random, quiet in calm stretches, solid during hold_off.
  always @(posedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else if (calm) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < 8);
  end

  task automatic send(logic [15:0] v, logic [31:0] p, logic [31:0] m, bit last);
    if (!calm) begin
      while ($urandom_range(99) < 8) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data <= '{sort_value: v, position: p, rank_mean: m, is_last: last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic go_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // Sends a run of n equal values, optionally ending the stream.
  task automatic send_run(int n, bit end_stream);
    cur_val = cur_val + 16'($urandom_range(1, 3));
    for (int i = 0; i < n; i++)
      send(cur_val, $urandom, $urandom, end_stream && i == n - 1);
  endtask

  initial begin
    sb = new();
    sb.clear();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: lone last item, extremes, ties, exact-full and split runs.
    send(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
    send(16'h0000, 32'h0, 32'h0, 0);
    send(16'h0001, 32'h1, 32'h1, 0);
    send(16'h0001, 32'h2, 32'h2, 0);
    send(16'h0002, 32'h3, 32'hFFFF_FFFF, 0);
    send(16'h0002, 32'h4, 32'hFFFF_FFFE, 1);
    cur_val = 16'h100;
    send_run(DEPTH, 1);
    send_run(DEPTH + 1, 0);
    send_run(2 * DEPTH + 1, 0);
    send_run(3, 1);
    go_quiet();

    // Hold off the receiver while the sender keeps offering items.
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 20; i++) send_run(1 + (i % 3), 0);
    join
    send_run(1, 1);
    go_quiet();

    for (int i = 0; i < 50; i++) begin
      int k;
      calm = (i >= 15 && i < 40);
      k = $urandom_range(99);
      if (k < 60) send_run(1, $urandom_range(9) == 0);
      else if (k < 95) send_run($urandom_range(2, 4), $urandom_range(5) == 0);
      else send(16'($urandom), $urandom, $urandom, 1'($urandom_range(1)));
    end
    calm = 0;
    send_run(1, 1);
    go_quiet();
    repeat (100) @(posedge clk);

    if (sb.errors == 0 && sb.pending.size() == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end
endmodule
